// ===== hw/rtl/gld_pkg.sv =====
`default_nettype none

package gld_pkg;

    // Byte codes on the link.
    localparam logic [7:0] ADDR_BASE  = 8'd201;
    localparam logic [7:0] ADDR_IDLE  = 8'd255;
    localparam logic [7:0] BTN_FIRST  = 8'd231;
    localparam logic [7:0] BTN_LAST   = 8'd246;
    localparam logic [7:0] DATA_MAX   = 8'd200;
    localparam logic [7:0] CHAN_RESET = 8'd100;
    localparam logic [7:0] IND_ON     = 8'hFF;
    localparam logic [7:0] IND_OFF    = 8'h00;

    // Number of stick channels that are kept.
    localparam int CHAN_KEPT = 4;
    localparam int CHAN_W    = $clog2(CHAN_KEPT);

    // Configuration register indexes.
    localparam logic CFG_FULL_SCALE  = 1'b0;
    localparam logic CFG_DRIVE_RANGE = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [7:0] FULL_SCALE_RESET  = 8'd200;
    localparam logic [7:0] DRIVE_RANGE_RESET = 8'd255;

    // Dividend is channel value times twice the range: 200 * 510 fits 17 bits.
    localparam int NUM_W     = 17;
    localparam int CNT_W     = $clog2(NUM_W);
    localparam int DRIVE_W   = 9;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_STORE,
        S_PUSH
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/gamepad_link_byte_decoder.sv =====
// Each accepted byte starts a pass in which each of the four channels takes a multiply,
// 17 divider steps and a clamp; the four results are then loaded together.
// The shared bit-serial divider serves one channel at a time, and no new byte is taken until
// the pass has loaded its result; the pass stalls before its load while an earlier result is still waiting to be taken.
// Reset (synchronous, active low) sets all channels to 100, no address selected,
// the indicator off and the configuration to full scale 200 and range 255.
`default_nettype none

module gamepad_link_byte_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Received byte stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    // Result stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [8:0] left_y_drive, [17:9] left_x_drive, [26:18] right_y_drive,
    // [35:27] right_x_drive, [43:36] indicator_level, [47:44] button_number
    output logic [47:0]      o_m_tdata,
    output logic             o_m_tuser,   // [0] button_pressed
    // Configuration writes.
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);
    import gld_pkg::*;

    t_state r_state, n_state;

    logic [7:0]             r_full_scale;
    logic [7:0]             r_drive_range;
    logic [7:0]             r_chan [CHAN_KEPT];
    logic [7:0]             r_addr;
    logic                   r_ind;
    logic                   r_pressed;
    logic [3:0]             r_btn_num;

    logic [CHAN_W-1:0]      r_ch;
    logic [CNT_W-1:0]       r_cnt;
    logic [NUM_W-1:0]       r_num;
    logic [7:0]             r_rem;
    logic signed [DRIVE_W-1:0] r_res [CHAN_KEPT];

    logic                   r_out_valid;
    logic [47:0]            r_out_data;
    logic                   r_out_user;

    logic                   in_accept;
    logic                   push_load;
    logic [7:0]             div_f;
    logic [8:0]             trial;
    logic                   trial_ge;
    logic [8:0]             two_r;
    logic [8:0]             q_clamp;
    logic [9:0]             drive_y;
    logic [9:0]             drive_x;
    logic [7:0]             ch_sel;
    logic                   is_addr;
    logic                   is_btn;
    logic [15:0]            product;

    // Handshake decodes.
    assign in_accept = i_s_tvalid && o_s_tready;
    assign push_load = (r_state == S_PUSH) && (!r_out_valid || i_m_tready);

    // Byte classification.
    assign is_addr = (i_s_tdata >= ADDR_BASE) && (i_s_tdata < ADDR_IDLE);
    assign is_btn  = (i_s_tdata >= BTN_FIRST) && (i_s_tdata <= BTN_LAST);
    assign ch_sel  = r_addr - ADDR_BASE;

    // Shared datapath: multiplier, one restoring divider step, and the clamp.
    assign product  = r_chan[r_ch] * r_drive_range;
    assign div_f    = (r_full_scale == 8'd0) ? 8'd1 : r_full_scale;
    assign trial    = {r_rem, r_num[NUM_W-1]};
    assign trial_ge = trial >= {1'b0, div_f};
    assign two_r    = {r_drive_range, 1'b0};
    assign q_clamp  = (r_num > {{(NUM_W-9){1'b0}}, two_r}) ? two_r : r_num[8:0];
    assign drive_y  = {1'b0, q_clamp} - {2'b00, r_drive_range};
    assign drive_x  = {2'b00, r_drive_range} - {1'b0, q_clamp};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_accept) n_state = S_MUL;
            S_MUL:   n_state = S_DIV;
            S_DIV:   if (r_cnt == CNT_W'(NUM_W - 1)) n_state = S_STORE;
            S_STORE: if (r_ch == CHAN_W'(CHAN_KEPT - 1)) n_state = S_PUSH;
                     else n_state = S_MUL;
            S_PUSH:  if (push_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE:  o_s_tready = 1'b1;
            default: o_s_tready = 1'b0;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    // Control state, configuration and decoder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_full_scale  <= FULL_SCALE_RESET;
            r_drive_range <= DRIVE_RANGE_RESET;
            for (int i = 0; i < CHAN_KEPT; i++) begin
                r_chan[i] <= CHAN_RESET;
            end
            r_addr        <= ADDR_IDLE;
            r_ind         <= 1'b0;
            r_out_valid   <= 1'b0;
            r_ch          <= '0;
            r_cnt         <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FULL_SCALE:  r_full_scale  <= i_cfg_data;
                    CFG_DRIVE_RANGE: r_drive_range <= i_cfg_data;
                    default: ;
                endcase
            end

            // Decode the accepted byte.
            if (in_accept) begin
                r_ch <= '0;
                if (is_addr) begin
                    r_addr <= i_s_tdata;
                    if (is_btn) begin
                        r_ind <= ~r_ind;
                    end
                end else if (i_s_tdata <= DATA_MAX) begin
                    if (ch_sel < 8'(CHAN_KEPT)) begin
                        r_chan[ch_sel[CHAN_W-1:0]] <= i_s_tdata;
                    end
                end
            end

            // Sequencer counters.
            case (r_state)
                S_MUL:   r_cnt <= '0;
                S_DIV:   r_cnt <= r_cnt + 1'b1;
                S_STORE: r_ch  <= r_ch + 1'b1;
                default: ;
            endcase

            // Output register.
            if (push_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: divider, per-channel results and the result word.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pressed <= is_addr && is_btn;
            r_btn_num <= (is_addr && is_btn) ? 4'(i_s_tdata - BTN_FIRST) : 4'd0;
        end

        case (r_state)
            S_MUL: begin
                r_num <= {product, 1'b0};
                r_rem <= '0;
            end
            S_DIV: begin
                r_num <= {r_num[NUM_W-2:0], trial_ge};
                r_rem <= trial_ge ? 8'(trial - {1'b0, div_f}) : trial[7:0];
            end
            S_STORE: begin
                // Odd channels are the X axes, which are inverted.
                r_res[r_ch] <= r_ch[0] ? $signed(drive_x[DRIVE_W-1:0])
                                       : $signed(drive_y[DRIVE_W-1:0]);
            end
            default: ;
        endcase

        if (push_load) begin
            r_out_data <= {r_btn_num, (r_ind ? IND_ON : IND_OFF),
                           r_res[3], r_res[2], r_res[1], r_res[0]};
            r_out_user <= r_pressed;
        end
    end

    // A byte is taken only when the sequencer is idle, and it starts a pass.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_MUL && !o_s_tready))
        else $error("accepted byte did not start the sequencer");

    // The divider step counter never runs past the last quotient bit.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= CNT_W'(NUM_W - 1)))
        else $error("divider counter overran");

    // A result waiting to be taken is not overwritten.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> $stable(r_out_data))
        else $error("pending result changed");

    // A report without a button press carries button number zero.
    a_btn_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[47:44] == 4'd0))
        else $error("button number set without a press");

endmodule

`default_nettype wire
